FILE: sv/gspe_pkg.sv
// Package for the grid shortest path engine: types, constants and the microcode table.
package gspe_pkg;

	localparam int GRID_COLUMNS_DEF = 7;
	localparam int GRID_ROWS_DEF    = 4;
	localparam int RELAX_ROUNDS_DEF = 10;
	localparam int DIST_WIDTH_DEF   = 8;

	localparam int RESULT_CAP = 28;
	localparam int WEIGHT_W   = 8;
	localparam int CFG_W      = 8;
	localparam int ACTION_W   = 2;
	localparam int STEP_W     = 4;

	localparam logic [WEIGHT_W-1:0] RESET_MAX_DIST = 8'hFF;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_BLOCK = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	// relaxation order within one node
	typedef enum logic [1:0] {
		DIR_E = 2'd0,
		DIR_W = 2'd1,
		DIR_N = 2'd2,
		DIR_S = 2'd3
	} dir_t;

	typedef enum logic [STEP_W-1:0] {
		S_CLEAR     = 4'd0,
		S_WAIT      = 4'd1,
		S_LOAD      = 4'd2,
		S_BLK_SELF  = 4'd3,
		S_BLK_NEIGH = 4'd4,
		S_QRANGE    = 4'd5,
		S_QSAME     = 4'd6,
		S_INIT      = 4'd7,
		S_RELAX     = 4'd8,
		S_RDEND     = 4'd9,
		S_TEST      = 4'd10,
		S_PREAD     = 4'd11,
		S_EMIT      = 4'd12,
		S_NOPATH    = 4'd13,
		S_EMPTY     = 4'd14
	} step_t;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_CLEAR,
		UOP_WAIT,
		UOP_LOAD,
		UOP_BLK_SELF,
		UOP_BLK_NEIGH,
		UOP_INIT,
		UOP_RELAX,
		UOP_RDEND,
		UOP_EMIT,
		UOP_NOPATH,
		UOP_EMPTY
	} uop_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_LOOP,
		C_DISPATCH,
		C_BAD_RANGE,
		C_SAME,
		C_FAR,
		C_EMIT
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic init_we;
		logic init_zero;
		logic relax_issue;
	} dist_ctl_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		unique case (s)
			S_CLEAR:     w = '{UOP_CLEAR,     C_LOOP,      S_CLEAR};
			S_WAIT:      w = '{UOP_WAIT,      C_DISPATCH,  S_WAIT};
			S_LOAD:      w = '{UOP_LOAD,      C_JUMP,      S_WAIT};
			S_BLK_SELF:  w = '{UOP_BLK_SELF,  C_NEXT,      S_WAIT};
			S_BLK_NEIGH: w = '{UOP_BLK_NEIGH, C_JUMP,      S_WAIT};
			S_QRANGE:    w = '{UOP_NOP,       C_BAD_RANGE, S_NOPATH};
			S_QSAME:     w = '{UOP_NOP,       C_SAME,      S_EMPTY};
			S_INIT:      w = '{UOP_INIT,      C_LOOP,      S_INIT};
			S_RELAX:     w = '{UOP_RELAX,     C_LOOP,      S_RELAX};
			S_RDEND:     w = '{UOP_RDEND,     C_NEXT,      S_WAIT};
			S_TEST:      w = '{UOP_NOP,       C_FAR,       S_NOPATH};
			S_PREAD:     w = '{UOP_NOP,       C_NEXT,      S_WAIT};
			S_EMIT:      w = '{UOP_EMIT,      C_EMIT,      S_PREAD};
			S_NOPATH:    w = '{UOP_NOPATH,    C_EMIT,      S_WAIT};
			S_EMPTY:     w = '{UOP_EMPTY,     C_EMIT,      S_WAIT};
			default:     w = '{UOP_NOP,       C_JUMP,      S_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/gspe_dist.sv
// Distance and predecessor store with the two-stage relax datapath.
module gspe_dist import gspe_pkg::*; #(
	parameter int NodeCount = GRID_COLUMNS_DEF * GRID_ROWS_DEF,
	parameter int DistW     = DIST_WIDTH_DEF,
	localparam int NodeW    = $clog2(NodeCount)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dist_ctl_t           ctl,
	input  logic [DistW-1:0]    lim,
	input  logic [NodeW-1:0]    node_a,
	input  logic [NodeW-1:0]    node_b,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic [NodeW-1:0]    pred_addr,
	output logic [DistW-1:0]    best_b,
	output logic [NodeW-1:0]    pred_rd
);

	logic [DistW-1:0] best_mem [NodeCount];
	logic [NodeW-1:0] pred_mem [NodeCount];

	logic [DistW-1:0] rd_a_q, rd_b_q, lastw_q;
	logic [NodeW-1:0] pred_rd_q, to_s2, from_s2;
	logic             issue_s2, byp_a_s2, byp_b_s2;

	logic [DistW-1:0] from_val, to_val, sat;
	logic [DistW:0]   sum;
	logic             upd;
	logic             best_we;
	logic [NodeW-1:0] best_wa;
	logic [DistW-1:0] best_wd;

	// stage 2: forward the write made at the same edge as the stage 1 read
	always_comb begin
		from_val = byp_a_s2 ? lastw_q : rd_a_q;
		to_val   = byp_b_s2 ? lastw_q : rd_b_q;
		sum      = {1'b0, from_val} + (DistW+1)'(weight);
		sat      = (sum > {1'b0, lim}) ? lim : sum[DistW-1:0];
		upd      = issue_s2 && (to_val > sat);
	end

	always_comb begin
		best_we = ctl.init_we || upd;
		best_wa = ctl.init_we ? node_a : to_s2;
		best_wd = ctl.init_we ? (ctl.init_zero ? '0 : lim) : sat;
	end

	always_ff @(posedge clk) begin
		if (best_we) begin
			best_mem[best_wa] <= best_wd;
		end
		if (upd) begin
			pred_mem[to_s2] <= from_s2;
		end
		rd_a_q    <= best_mem[node_a];
		rd_b_q    <= best_mem[node_b];
		pred_rd_q <= pred_mem[pred_addr];
	end

	always_ff @(posedge clk) begin
		to_s2   <= node_b;
		from_s2 <= node_a;
		lastw_q <= sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s2 <= 1'b0;
			byp_a_s2 <= 1'b0;
			byp_b_s2 <= 1'b0;
		end else begin
			issue_s2 <= ctl.relax_issue;
			byp_a_s2 <= upd && (to_s2 == node_a);
			byp_b_s2 <= upd && (to_s2 == node_b);
		end
	end

	assign best_b  = to_val;
	assign pred_rd = pred_rd_q;

	a_init_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.init_we |-> !issue_s2)
		else $error("init write collides with a relax write");

	a_from_stable: assert property (@(posedge clk) disable iff (!arst_n)
		upd |-> (to_s2 != from_s2))
		else $error("relax writes its own source node");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		upd |-> (sat <= lim))
		else $error("relaxed distance above limit");

endmodule

FILE: sv/grid_shortest_path_engine.sv
// Top level of the grid shortest path engine: microcoded sequencer, weight stores, output register.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tdata: action, node_index, weight_n/e/s/w, start_node, end_node
// m_*      out  m_tvalid/m_tready   tdata: path_node; tlast: last; tuser: no_path, empty_path
// cfg_*    in   cfg_we              cfg_wdata: max_dist
//
// A load and a block each run their own steps and return to the wait step. A query initialises
// all N nodes, runs RELAX_ROUNDS rounds over the four directions of every node, one relax step
// a cycle on the distance store, and emits one result per path node. After reset a clearing pass
// over all N nodes fills the weight stores before the first transfer. Results wait in the output
// register; the sequencer holds its emit step while that register is full and m_tready is low.
module grid_shortest_path_engine import gspe_pkg::*; #(
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = GRID_ROWS_DEF,
	parameter int RELAX_ROUNDS = RELAX_ROUNDS_DEF,
	parameter int DIST_WIDTH   = DIST_WIDTH_DEF,
	localparam int NodeCount   = GRID_COLUMNS * GRID_ROWS,
	localparam int NodeW       = $clog2(NodeCount),
	localparam int InBits      = ACTION_W + NodeW + 4 * WEIGHT_W + 2 * NodeW,
	localparam int InW         = ((InBits + 7) / 8) * 8,
	localparam int OutW        = ((NodeW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// action, node_index, weight_north, weight_east, weight_south, weight_west,
	// start_node, end_node
	input  logic [InW-1:0]   s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// path_node
	output logic [OutW-1:0]  m_tdata,
	output logic             m_tlast,
	// no_path, empty_path
	output logic [1:0]       m_tuser
);

	localparam int ColW     = $clog2(GRID_COLUMNS);
	localparam int RowW     = $clog2(GRID_ROWS);
	localparam int RoundW   = (RELAX_ROUNDS > 1) ? $clog2(RELAX_ROUNDS) : 1;
	localparam int KW       = $clog2(RESULT_CAP);
	localparam int OffNode  = ACTION_W;
	localparam int OffWn    = OffNode + NodeW;
	localparam int OffWe    = OffWn + WEIGHT_W;
	localparam int OffWs    = OffWe + WEIGHT_W;
	localparam int OffWw    = OffWs + WEIGHT_W;
	localparam int OffStart = OffWw + WEIGHT_W;
	localparam int OffEnd   = OffStart + NodeW;

	step_t  step_q, step_d;
	uword_t uw;

	logic [CFG_W-1:0]             max_dist_q;
	logic [NodeW-1:0]             node_q, start_q, end_q, cur_q;
	logic [3:0][WEIGHT_W-1:0]     wgt_q;
	logic [NodeW-1:0]             i_q;
	logic [ColW-1:0]              col_q;
	logic [RowW-1:0]              row_q;
	dir_t                         d_q, dir_s2;
	logic [RoundW-1:0]            r_q;
	logic [KW-1:0]                k_q;

	logic                         in_acc;
	action_t                      in_action;
	logic                         node_last, round_last, relax_last, loop_done;
	logic                         node_ok, first_col, last_col, first_row, last_row;
	logic                         nb_ok;
	logic [NodeW-1:0]             to_node;
	logic                         bad_range, same_node, far_end, fin;

	logic [3:0]                   wm_we;
	logic [3:0][NodeW-1:0]        wm_wa;
	logic [3:0][WEIGHT_W-1:0]     wm_wd;
	logic [3:0][WEIGHT_W-1:0]     wm_rd_q;

	dist_ctl_t                    dctl;
	logic [DIST_WIDTH-1:0]        lim, best_b;
	logic [NodeW-1:0]             node_b, pred_rd;

	logic                         out_valid_q, out_free, out_load;
	logic [NodeW-1:0]             out_node_q, out_node_d;
	logic                         out_last_q, out_last_d;
	logic                         out_np_q, out_np_d;
	logic                         out_em_q, out_em_d;

	assign uw        = ucode(step_q);
	assign s_tready  = (step_q == S_WAIT);
	assign in_acc    = s_tvalid && s_tready;
	assign in_action = action_t'(s_tdata[ACTION_W-1:0]);
	assign lim       = DIST_WIDTH'(max_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= RESET_MAX_DIST;
		end else if (cfg_we) begin
			max_dist_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			node_q       <= s_tdata[OffNode +: NodeW];
			wgt_q[DIR_N] <= s_tdata[OffWn +: WEIGHT_W];
			wgt_q[DIR_E] <= s_tdata[OffWe +: WEIGHT_W];
			wgt_q[DIR_S] <= s_tdata[OffWs +: WEIGHT_W];
			wgt_q[DIR_W] <= s_tdata[OffWw +: WEIGHT_W];
			start_q      <= s_tdata[OffStart +: NodeW];
			end_q        <= s_tdata[OffEnd +: NodeW];
		end
	end

	// node geometry for load and block
	always_comb begin
		first_col = 1'b0;
		last_col  = 1'b0;
		for (int r = 0; r < GRID_ROWS; r++) begin
			if (node_q == NodeW'(r * GRID_COLUMNS)) begin
				first_col = 1'b1;
			end
			if (node_q == NodeW'(r * GRID_COLUMNS + GRID_COLUMNS - 1)) begin
				last_col = 1'b1;
			end
		end
		node_ok   = (NodeW+1)'(node_q) < (NodeW+1)'(NodeCount);
		first_row = (NodeW+1)'(node_q) < (NodeW+1)'(GRID_COLUMNS);
		last_row  = (NodeW+1)'(node_q) >= (NodeW+1)'(NodeCount - GRID_COLUMNS);
	end

	// relax neighbor of the current sweep position
	always_comb begin
		unique case (d_q)
			DIR_E: begin
				nb_ok   = col_q != ColW'(GRID_COLUMNS - 1);
				to_node = i_q + NodeW'(1);
			end
			DIR_W: begin
				nb_ok   = col_q != '0;
				to_node = i_q - NodeW'(1);
			end
			DIR_N: begin
				nb_ok   = row_q != '0;
				to_node = i_q - NodeW'(GRID_COLUMNS);
			end
			DIR_S: begin
				nb_ok   = row_q != RowW'(GRID_ROWS - 1);
				to_node = i_q + NodeW'(GRID_COLUMNS);
			end
			default: begin
				nb_ok   = 1'b0;
				to_node = i_q;
			end
		endcase
	end

	always_comb begin
		node_last  = i_q == NodeW'(NodeCount - 1);
		round_last = r_q == RoundW'(RELAX_ROUNDS - 1);
		relax_last = round_last && node_last && (d_q == DIR_S);
		loop_done  = (uw.op == UOP_RELAX) ? relax_last : node_last;
		bad_range  = ((NodeW+1)'(start_q) >= (NodeW+1)'(NodeCount)) ||
		             ((NodeW+1)'(end_q) >= (NodeW+1)'(NodeCount));
		same_node  = start_q == end_q;
		far_end    = best_b >= lim;
		fin        = (pred_rd == start_q) ||
		             ((NodeW+1)'(pred_rd) >= (NodeW+1)'(NodeCount)) ||
		             (k_q == KW'(RESULT_CAP - 1));
		out_free   = !out_valid_q || m_tready;
	end

	// next step
	always_comb begin
		step_d = step_q;
		unique case (uw.cond)
			C_NEXT: step_d = step_t'(step_q + STEP_W'(1));
			C_JUMP: step_d = uw.target;
			C_LOOP: step_d = loop_done ? step_t'(step_q + STEP_W'(1)) : uw.target;
			C_DISPATCH: begin
				if (in_acc) begin
					unique case (in_action)
						ACT_LOAD:  step_d = S_LOAD;
						ACT_BLOCK: step_d = S_BLK_SELF;
						ACT_QUERY: step_d = S_QRANGE;
						default:   step_d = S_WAIT;
					endcase
				end
			end
			C_BAD_RANGE: step_d = bad_range ? uw.target : step_t'(step_q + STEP_W'(1));
			C_SAME:      step_d = same_node ? uw.target : step_t'(step_q + STEP_W'(1));
			C_FAR:       step_d = far_end ? uw.target : step_t'(step_q + STEP_W'(1));
			C_EMIT: begin
				if (out_free) begin
					step_d = out_last_d ? S_WAIT : uw.target;
				end
			end
			default: step_d = S_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_CLEAR;
		end else begin
			step_q <= step_d;
		end
	end

	// control word decode
	always_comb begin
		for (int g = 0; g < 4; g++) begin
			wm_we[g] = 1'b0;
			wm_wa[g] = node_q;
			wm_wd[g] = wgt_q[g];
		end
		unique case (uw.op)
			UOP_CLEAR: begin
				for (int g = 0; g < 4; g++) begin
					wm_we[g] = 1'b1;
					wm_wa[g] = i_q;
					wm_wd[g] = RESET_MAX_DIST;
				end
			end
			UOP_LOAD: begin
				wm_we = {4{node_ok}};
			end
			UOP_BLK_SELF: begin
				wm_we = {4{node_ok}};
				wm_wd = {4{max_dist_q}};
			end
			UOP_BLK_NEIGH: begin
				wm_wd        = {4{max_dist_q}};
				wm_we[DIR_E] = node_ok && !first_col;
				wm_wa[DIR_E] = node_q - NodeW'(1);
				wm_we[DIR_W] = node_ok && !last_col;
				wm_wa[DIR_W] = node_q + NodeW'(1);
				wm_we[DIR_N] = node_ok && !last_row;
				wm_wa[DIR_N] = node_q + NodeW'(GRID_COLUMNS);
				wm_we[DIR_S] = node_ok && !first_row;
				wm_wa[DIR_S] = node_q - NodeW'(GRID_COLUMNS);
			end
			default: ;
		endcase

		dctl.init_we     = uw.op == UOP_INIT;
		dctl.init_zero   = i_q == start_q;
		dctl.relax_issue = (uw.op == UOP_RELAX) && nb_ok;
		node_b           = (uw.op == UOP_RDEND) ? end_q : to_node;

		unique case (uw.op)
			UOP_NOPATH: begin
				out_node_d = '0;
				out_last_d = 1'b1;
				out_np_d   = 1'b1;
				out_em_d   = 1'b0;
			end
			UOP_EMPTY: begin
				out_node_d = '0;
				out_last_d = 1'b1;
				out_np_d   = 1'b0;
				out_em_d   = 1'b1;
			end
			default: begin
				out_node_d = cur_q;
				out_last_d = fin;
				out_np_d   = 1'b0;
				out_em_d   = 1'b0;
			end
		endcase
		out_load = out_free &&
		           ((uw.op == UOP_EMIT) || (uw.op == UOP_NOPATH) || (uw.op == UOP_EMPTY));
	end

	// sweep and result counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			col_q <= '0;
			row_q <= '0;
			d_q   <= DIR_E;
			r_q   <= '0;
			k_q   <= '0;
		end else begin
			case (uw.op) inside
				UOP_WAIT: begin
					i_q   <= '0;
					col_q <= '0;
					row_q <= '0;
					d_q   <= DIR_E;
					r_q   <= '0;
					k_q   <= '0;
				end
				UOP_CLEAR, UOP_INIT: begin
					i_q <= node_last ? '0 : i_q + NodeW'(1);
				end
				UOP_RELAX: begin
					d_q <= dir_t'(d_q + 2'd1);
					if (d_q == DIR_S) begin
						if (node_last) begin
							i_q   <= '0;
							col_q <= '0;
							row_q <= '0;
							r_q   <= round_last ? '0 : r_q + RoundW'(1);
						end else begin
							i_q <= i_q + NodeW'(1);
							if (col_q == ColW'(GRID_COLUMNS - 1)) begin
								col_q <= '0;
								row_q <= row_q + RowW'(1);
							end else begin
								col_q <= col_q + ColW'(1);
							end
						end
					end
				end
				UOP_EMIT: begin
					if (out_free) begin
						k_q <= k_q + KW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == UOP_RDEND) begin
			cur_q <= end_q;
		end else if ((uw.op == UOP_EMIT) && out_free) begin
			cur_q <= pred_rd;
		end
		dir_s2 <= d_q;
	end

	for (genvar g = 0; g < 4; g++) begin : g_wmem
		logic [WEIGHT_W-1:0] wmem [NodeCount];
		always_ff @(posedge clk) begin
			if (wm_we[g]) begin
				wmem[wm_wa[g]] <= wm_wd[g];
			end
			wm_rd_q[g] <= wmem[i_q];
		end
	end

	gspe_dist #(
		.NodeCount(NodeCount),
		.DistW    (DIST_WIDTH)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.lim      (lim),
		.node_a   (i_q),
		.node_b   (node_b),
		.weight   (wm_rd_q[dir_s2]),
		.pred_addr(cur_q),
		.best_b   (best_b),
		.pred_rd  (pred_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_node_q <= out_node_d;
			out_last_q <= out_last_d;
			out_np_q   <= out_np_d;
			out_em_q   <= out_em_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OutW'(out_node_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_em_q, out_np_q};

	a_nb_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.relax_issue |-> ((NodeW+1)'(to_node) < (NodeW+1)'(NodeCount)))
		else $error("relax toward a node outside the grid");

	a_last_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (step_q == S_WAIT))
		else $error("sequencer did not return after the final result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("no_path and empty_path both set");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == UOP_EMIT) |-> (k_q <= KW'(RESULT_CAP - 1)))
		else $error("result count beyond cap");

endmodule
